// ----- hw/rtl/qry_pkg.sv -----
`default_nettype none
package qry_pkg;

   // Q1.14 working width of each component
   localparam int unsigned QW = 16;
   // difference components, Q2.28 plus headroom
   localparam int unsigned DW = 34;
   // CORDIC datapath width
   localparam int unsigned CW = 64;
   // angle accumulator, 2^-16 degree
   localparam int unsigned ZW = 32;
   localparam int unsigned MAX_STAGES = 32;

   localparam logic signed [ZW-1:0] Z_QUARTER = 32'sd5898240;

   // atan(2^-s) in degrees times 65536, rounded
   function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] s);
      logic signed [ZW-1:0] r;
      unique case (s)
         5'd0: r = 32'sd2949120;
         5'd1: r = 32'sd1740967;
         5'd2: r = 32'sd919879;
         5'd3: r = 32'sd466945;
         5'd4: r = 32'sd234379;
         5'd5: r = 32'sd117304;
         5'd6: r = 32'sd58666;
         5'd7: r = 32'sd29335;
         5'd8: r = 32'sd14668;
         5'd9: r = 32'sd7334;
         5'd10: r = 32'sd3667;
         5'd11: r = 32'sd1833;
         5'd12: r = 32'sd917;
         5'd13: r = 32'sd458;
         5'd14: r = 32'sd229;
         5'd15: r = 32'sd115;
         5'd16: r = 32'sd57;
         5'd17: r = 32'sd29;
         5'd18: r = 32'sd14;
         5'd19: r = 32'sd7;
         5'd20: r = 32'sd4;
         5'd21: r = 32'sd2;
         5'd22: r = 32'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // payload travelling along the CORDIC chain
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 num_zero;
      logic                 den_neg;
      logic                 degenerate;
   } cell_type;

endpackage
`default_nettype wire

// ----- hw/rtl/qry_cell.sv -----
`default_nettype none
// One vectoring CORDIC cell: a single micro-rotation, registered.
module qry_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire qry_pkg::cell_type  in_data,
   output logic                    out_valid,
   output qry_pkg::cell_type       out_data
);
   logic               valid_ff;
   qry_pkg::cell_type  data_ff, data_in;
   logic signed [qry_pkg::CW-1:0] xs, ys;

   // rotate toward the x axis
   always_comb begin
      xs = in_data.x >>> SHIFT;
      ys = in_data.y >>> SHIFT;
      data_in = in_data;
      if (in_data.y > 0) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + qry_pkg::atan_lut(5'(SHIFT));
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - qry_pkg::atan_lut(5'(SHIFT));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/qry_front.sv -----
`default_nettype none
// Difference quaternion, block normalisation and atan2 argument forming.
// Stages: products, sums, normalise, squares and cross products, num/den plus quadrant fold.
module qry_front #(
   parameter int unsigned COMPONENT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire logic                              in_valid,
   input  wire logic [8*COMPONENT_WIDTH-1:0]      in_comp,
   output logic                                   out_valid,
   output qry_pkg::cell_type                      out_data
);
   localparam int unsigned QW = qry_pkg::QW;
   localparam int unsigned DW = qry_pkg::DW;
   localparam int unsigned PW = 2*QW;

   logic signed [QW-1:0] q [8];
   logic [4:0] v_ff;

   // bring each component to Q1.14
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         if (COMPONENT_WIDTH >= QW) begin
            q[n] = QW'($signed(in_comp[n*COMPONENT_WIDTH +: COMPONENT_WIDTH])
                      >>> (COMPONENT_WIDTH - QW));
         end else begin
            q[n] = QW'($signed(in_comp[n*COMPONENT_WIDTH +: COMPONENT_WIDTH]))
                   <<< (QW - COMPONENT_WIDTH);
         end
      end
   end

   // stage 1: sixteen products
   logic signed [PW-1:0] p_ff [16];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
               p_ff[a*4+b] <= q[a] * q[4+b];
            end
         end
      end
   end

   // stage 2: difference components
   logic signed [DW-1:0] d_ff [4];
   function automatic logic signed [DW-1:0] ext(input logic signed [PW-1:0] v);
      return DW'(v);
   endfunction
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= ext(p_ff[0]) + ext(p_ff[5]) + ext(p_ff[10]) + ext(p_ff[15]);
         d_ff[1] <= ext(p_ff[1]) - ext(p_ff[4]) - ext(p_ff[11]) + ext(p_ff[14]);
         d_ff[2] <= ext(p_ff[2]) + ext(p_ff[7]) - ext(p_ff[8]) - ext(p_ff[13]);
         d_ff[3] <= ext(p_ff[3]) - ext(p_ff[6]) + ext(p_ff[9]) - ext(p_ff[12]);
      end
   end

   // stage 3: common shift so the largest magnitude lies in [2^27, 2^28)
   logic          zero;
   logic signed [29:0] n_in [4];
   logic signed [29:0] n_ff [4];
   logic zero_ff;
   always_comb begin
      zero = 1'b1;
      for (int n = 0; n < 4; n++) begin
         zero &= (d_ff[n] == '0);
      end
   end

   // exact maximum magnitude needed: do it by compare of |d|
   logic [DW-1:0] mag [4];
   logic [DW-1:0] amag;
   logic [6:0]    top;
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         mag[n] = d_ff[n][DW-1] ? DW'(-d_ff[n]) : DW'(d_ff[n]);
      end
      amag = mag[0];
      for (int n = 1; n < 4; n++) begin
         if (mag[n] > amag) amag = mag[n];
      end
      top = '0;
      for (int b = 0; b < DW; b++) begin
         if (amag[b]) top = 7'(b);
      end
   end

   logic signed [DW+28-1:0] wide [4];
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         wide[n] = (DW+28)'(d_ff[n]);
         if (top >= 7'd28) begin
            n_in[n] = 30'(d_ff[n] >>> (top - 7'd27));
         end else begin
            n_in[n] = 30'(wide[n] <<< (7'd27 - top));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) n_ff[n] <= n_in[n];
         zero_ff <= zero;
      end
   end

   // stage 4: products of normalised components
   logic signed [59:0] s_ff [6];
   logic zero2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff[0] <= n_ff[0] * n_ff[3];
         s_ff[1] <= n_ff[1] * n_ff[2];
         s_ff[2] <= n_ff[0] * n_ff[0];
         s_ff[3] <= n_ff[1] * n_ff[1];
         s_ff[4] <= n_ff[2] * n_ff[2];
         s_ff[5] <= n_ff[3] * n_ff[3];
         zero2_ff <= zero_ff;
      end
   end

   // stage 5: num/den and quadrant fold
   logic signed [qry_pkg::CW-1:0] num, den;
   qry_pkg::cell_type o_in, o_ff;
   always_comb begin
      num = (qry_pkg::CW'(s_ff[0]) + qry_pkg::CW'(s_ff[1])) <<< 1;
      den = qry_pkg::CW'(s_ff[2]) + qry_pkg::CW'(s_ff[3])
            - qry_pkg::CW'(s_ff[4]) - qry_pkg::CW'(s_ff[5]);
      o_in.num_zero   = (num == '0);
      o_in.den_neg    = den[qry_pkg::CW-1];
      o_in.degenerate = zero2_ff;
      o_in.x = den;
      o_in.y = num;
      o_in.z = '0;
      if (den < 0) begin
         if (num >= 0) begin
            o_in.x = num;
            o_in.y = -den;
            o_in.z = qry_pkg::Z_QUARTER;
         end else begin
            o_in.x = -num;
            o_in.y = den;
            o_in.z = -qry_pkg::Z_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
      if (adv) o_ff <= o_in;
   end

   assign out_valid = v_ff[4];
   assign out_data  = o_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_relative_yaw_top.sv -----
`default_nettype none
// Channel | Ports              | Payload
// req     | req_tvalid/tready  | tdata: first_w,i,j,k, second_w,i,j,k
// rsp     | rsp_tvalid/tready  | tdata: yaw_centideg; tuser: degenerate
// One pair accepted per cycle while no result is stalled at rsp; each pair passes
// through the product/normalise stages, the row of CORDIC cells and the output register.
// The whole pipe advances when the output register is empty or being taken,
// so req_tready drops only while a result is stalled at rsp.
// Synchronous reset clears all valid bits.
module quaternion_relative_yaw_top #(
   parameter int unsigned COMPONENT_WIDTH = 16,
   parameter int unsigned CORDIC_STAGES   = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // first_w, first_i, first_j, first_k, second_w, second_i, second_j, second_k
   input  wire logic [((8*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // yaw_centideg
   output logic [15:0]                       rsp_tdata,
   // degenerate
   output logic                              rsp_tuser
);
   logic adv;
   logic              v [CORDIC_STAGES+1];
   qry_pkg::cell_type c [CORDIC_STAGES+1];

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   qry_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
      .clock, .reset, .adv,
      .in_valid (req_tvalid),
      .in_comp  (req_tdata[8*COMPONENT_WIDTH-1:0]),
      .out_valid(v[0]),
      .out_data (c[0])
   );

   // row of CORDIC cells
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      qry_cell #(.SHIFT(g)) u_cell (
         .clock, .reset, .adv,
         .in_valid (v[g]),
         .in_data  (c[g]),
         .out_valid(v[g+1]),
         .out_data (c[g+1])
      );
   end

   // round to centidegrees, wrap and clamp; degenerate and zero-numerator cases override
   qry_pkg::cell_type last;
   logic signed [47:0] cd;
   logic signed [15:0] yaw_in, yaw_ff;
   logic deg_ff, valid_ff;
   always_comb begin
      last = c[CORDIC_STAGES];
      cd = ((48'(last.z) * 48'sd100) + 48'sd32768) >>> 16;
      if (cd > 48'sd18000) cd = cd - 48'sd36000;
      if (cd < -48'sd18000) cd = cd + 48'sd36000;
      if (cd > 48'sd18000) cd = 48'sd18000;
      if (cd < -48'sd18000) cd = -48'sd18000;
      priority if (last.degenerate) begin
         yaw_in = '0;
      end else if (last.num_zero) begin
         yaw_in = last.den_neg ? 16'sd18000 : 16'sd0;
      end else begin
         yaw_in = 16'(cd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= v[CORDIC_STAGES];
      end
      if (adv) begin
         yaw_ff <= yaw_in;
         deg_ff <= last.degenerate;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = yaw_ff;
   assign rsp_tuser  = deg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'd0)
      else $error("degenerate result with nonzero yaw");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= 16'sd18000 && $signed(rsp_tdata) >= -16'sd18000))
      else $error("yaw out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule
`default_nettype wire

// ----- tb/sv/quaternion_relative_yaw_top_tb.sv -----
`default_nettype none
module quaternion_relative_yaw_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [15:0] comp_t;

   // packed so that first_w lands in the lowest bits of tdata
   typedef struct packed {
      comp_t sk, sj, si, sw, fk, fj, fi, fw;
   } quat_pair_t;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic               degenerate;
   } heading_t;

   // atan(2^-s) in degrees, scaled by 2^16
   localparam longint ATAN_DEG16 [16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};
   localparam int STALL_CUTOFF = 100;
   localparam int WATCHDOG_LIMIT = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic         rsp_tuser;

   quaternion_relative_yaw_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   quat_pair_t pending_pairs[$];
   bit         wait_for_drain[$];
   heading_t   expected_headings[$];
   quat_pair_t pair_on_bus;
   int         send_gap = 0;
   int         take_gap = 0;
   int         idle_cycles = 0;
   int         error_count = 0;

   // yaw of conj(q1)*q2, centidegrees, via block-normalised CORDIC
   function automatic heading_t predict_heading(quat_pair_t p);
      longint w1, i1, j1, k1, w2, i2, j2, k2;
      longint d[4];
      longint num, den, x, y, z, t, xs, ys, yaw;
      longint unsigned amag, m;
      int r;
      heading_t h;
      w1 = p.fw; i1 = p.fi; j1 = p.fj; k1 = p.fk;
      w2 = p.sw; i2 = p.si; j2 = p.sj; k2 = p.sk;
      d[0] = w1*w2 + i1*i2 + j1*j2 + k1*k2;
      d[1] = w1*i2 - i1*w2 - j1*k2 + k1*j2;
      d[2] = w1*j2 + i1*k2 - j1*w2 - k1*i2;
      d[3] = w1*k2 - i1*j2 + j1*i2 - k1*w2;
      amag = 0;
      for (int n = 0; n < 4; n++) begin
         m = (d[n] < 0) ? -d[n] : d[n];
         if (m > amag) amag = m;
      end
      if (amag == 0) begin
         h.yaw = '0;
         h.degenerate = 1'b1;
         return h;
      end
      // bring the largest magnitude into [2^27, 2^28)
      r = 0;
      if (amag >= (64'd1 << 28)) begin
         while ((amag >> r) >= (64'd1 << 28)) r++;
         for (int n = 0; n < 4; n++) d[n] = d[n] >>> r;
      end else begin
         while ((amag << r) < (64'd1 << 27)) r++;
         for (int n = 0; n < 4; n++) d[n] = d[n] <<< r;
      end
      num = 2 * (d[0]*d[3] + d[1]*d[2]);
      den = d[0]*d[0] + d[1]*d[1] - d[2]*d[2] - d[3]*d[3];
      if (num == 0) begin
         yaw = (den < 0) ? 18000 : 0;
      end else begin
         x = den; y = num; z = 0;
         // fold left half-plane into the CORDIC range
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
               t = x; x = -y; y = t; z = -90 * 65536;
            end
         end
         for (int s = 0; s < 16; s++) begin
            xs = x >>> s;
            ys = y >>> s;
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + ATAN_DEG16[s];
            end else begin
               x = x - ys; y = y + xs; z = z - ATAN_DEG16[s];
            end
         end
         yaw = (z * 100 + 32768) >>> 16;
         if (yaw > 18000) yaw -= 36000;
         if (yaw < -18000) yaw += 36000;
         if (yaw > 18000) yaw = 18000;
         if (yaw < -18000) yaw = -18000;
      end
      h.yaw = yaw[15:0];
      h.degenerate = 1'b0;
      return h;
   endfunction

   function automatic comp_t unit_comp();
      return comp_t'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic quat_pair_t make_pair(comp_t fw, comp_t fi, comp_t fj, comp_t fk,
                                            comp_t sw, comp_t si, comp_t sj, comp_t sk);
      quat_pair_t p;
      p.fw = fw; p.fi = fi; p.fj = fj; p.fk = fk;
      p.sw = sw; p.si = si; p.sj = sj; p.sk = sk;
      return p;
   endfunction

   task automatic queue_pair(quat_pair_t p, bit drain);
      pending_pairs.push_back(p);
      wait_for_drain.push_back(drain);
   endtask

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_headings.push_back(predict_heading(pair_on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_pairs.size() == 0 ||
                         (wait_for_drain[0] && expected_headings.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else if (pending_pairs.size() > STALL_CUTOFF &&
                         $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 12);
               req_tvalid <= 1'b0;
            end else begin
               pair_on_bus = pending_pairs.pop_front();
               void'(wait_for_drain.pop_front());
               req_tdata <= pair_on_bus;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      heading_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_headings.size() == 0) begin
               $error("unexpected beat: yaw_centideg %0d degenerate %0d",
                      $signed(rsp_tdata), rsp_tuser);
               error_count++;
            end else begin
               want = expected_headings.pop_front();
               if (rsp_tdata !== want.yaw) begin
                  $error("yaw_centideg: expected %0d, actual %0d",
                         want.yaw, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser !== want.degenerate) begin
                  $error("degenerate: expected %0d, actual %0d",
                         want.degenerate, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_tready <= 1'b0;
         end else if (pending_pairs.size() > STALL_CUTOFF &&
                      $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         // watchdog on cycles without any accepted beat
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      comp_t a, b, c, e;
      quat_pair_t p;
      // directed: zero difference, identity, quarter and half turns, extremes
      queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 0, 0, 0, 0), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 0, 0, 0, 16384), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 11585, 0, 0, 11585), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 11585, 0, 0, -11585), 0);
      queue_pair(make_pair(16384, 0, 0, 0, -11585, 0, 0, 11585), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 0, 0, 16384, 0), 0);
      queue_pair(make_pair(0, 0, 0, 16384, 16384, 0, 0, 0), 0);
      queue_pair(make_pair(-16384, -16384, -16384, -16384, 16384, 16384, 16384, 16384), 0);
      queue_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
      queue_pair(make_pair(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767), 0);
      queue_pair(make_pair(1, 0, 0, 0, 0, 0, 0, 1), 0);
      queue_pair(make_pair(1, 0, 0, 0, 1, 0, 0, 0), 0);
      queue_pair(make_pair(16384, 0, 0, 0, -16384, 0, 0, 1), 0);
      queue_pair(make_pair(16384, 0, 0, 0, -16384, 0, 0, -1), 0);
      queue_pair(make_pair(16384, 0, 0, 0, 16384, 0, 0, -1), 0);
      queue_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 0);
      // random: mostly in-range pairs, some near-equal, some raw bit noise
      for (int n = 0; n < 950; n++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               p = $urandom();
               p[127:32] = {$urandom(), $urandom(), $urandom()};
            end
            2, 3: begin
               a = unit_comp(); b = unit_comp(); c = unit_comp(); e = unit_comp();
               p = make_pair(a, b, c, e,
                             a + comp_t'(int'($urandom_range(0, 64)) - 32),
                             b + comp_t'(int'($urandom_range(0, 64)) - 32),
                             c + comp_t'(int'($urandom_range(0, 64)) - 32),
                             e + comp_t'(int'($urandom_range(0, 64)) - 32));
            end
            default:
               p = make_pair(unit_comp(), unit_comp(), unit_comp(), unit_comp(),
                             unit_comp(), unit_comp(), unit_comp(), unit_comp());
         endcase
         queue_pair(p, n == 300 || n == 700);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_pairs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_headings.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_headings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
